// ----- rtl/core/utf8v_pkg.sv -----
// Shared types, error codes and code point checks for the UTF-8 text validator.
package utf8v_pkg;

    // Error codes reported with each string result
    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_LONG  = 3'd1;
    localparam logic [2:0] ERR_LEAD  = 3'd2;
    localparam logic [2:0] ERR_TRUNC = 3'd3;
    localparam logic [2:0] ERR_CONT  = 3'd4;
    localparam logic [2:0] ERR_POINT = 3'd5;

    // Byte counter saturation value and register reset value
    localparam logic [12:0] COUNT_MAX       = 13'd8191;
    localparam logic [11:0] MAX_BYTES_RESET = 12'd64;

    // One request on the input channel
    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_item;

    // One request on the output channel
    typedef struct packed {
        logic       valid_res;
        logic [2:0] error_code;
    } t_result;

    // True when a finished code point is overlong, a surrogate, out of range or a control.
    function automatic logic point_bad(input logic [20:0] cp, input logic [1:0] extra);
        logic bad;
        begin
            bad = 1'b0;
            if (extra == 2'd1 && cp < 21'h000080) bad = 1'b1;
            if (extra == 2'd2 && cp < 21'h000800) bad = 1'b1;
            if (extra == 2'd3 && cp < 21'h010000) bad = 1'b1;
            if (cp > 21'h10FFFF) bad = 1'b1;
            if (cp inside {[21'h00D800:21'h00DFFF]}) bad = 1'b1;
            if (cp < 21'h000020) bad = 1'b1;
            if (cp inside {[21'h00007F:21'h00009F]}) bad = 1'b1;
            return bad;
        end
    endfunction

endpackage

// ----- rtl/core/utf8v_decode.sv -----
// Running UTF-8 decode state and the per-string verdict, one byte per cycle while bytes are taken.
module utf8v_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  utf8v_pkg::t_item  i_item,
    input  logic [11:0]       i_max_bytes,
    output utf8v_pkg::t_result o_result
);
    import utf8v_pkg::*;

    logic [1:0]  r_pend, n_pend;
    logic [1:0]  r_seq,  n_seq;
    logic [20:0] r_cp,   n_cp;
    logic [12:0] r_cnt,  n_cnt;
    logic [2:0]  r_err,  n_err;
    logic [7:0]  b;
    logic [2:0]  code;

    assign b = i_item.text_byte;

    // Next decode state for the byte in hand.
    always_comb begin
        n_cnt  = (r_cnt < COUNT_MAX) ? r_cnt + 13'd1 : r_cnt;
        n_pend = r_pend;
        n_seq  = r_seq;
        n_cp   = r_cp;
        n_err  = r_err;
        if (r_err != ERR_NONE) begin
            // After an error only the owed continuation bytes are counted off.
            if (r_pend != 2'd0) n_pend = r_pend - 2'd1;
        end else if (r_pend == 2'd0) begin
            // Lead byte of a new sequence.
            if (b < 8'h80) begin
                if (point_bad({13'd0, b}, 2'd0)) n_err = ERR_POINT;
            end else if (b inside {[8'hC0:8'hDF]}) begin
                n_pend = 2'd1;
                n_seq  = 2'd1;
                n_cp   = {16'd0, b[4:0]};
            end else if (b inside {[8'hE0:8'hEF]}) begin
                n_pend = 2'd2;
                n_seq  = 2'd2;
                n_cp   = {17'd0, b[3:0]};
            end else if (b inside {[8'hF0:8'hF7]}) begin
                n_pend = 2'd3;
                n_seq  = 2'd3;
                n_cp   = {18'd0, b[2:0]};
            end else begin
                n_err = ERR_LEAD;
            end
        end else begin
            // Continuation byte of the open sequence.
            n_pend = r_pend - 2'd1;
            if (b[7:6] != 2'b10) begin
                n_err = ERR_CONT;
            end else begin
                n_cp = {r_cp[14:0], b[5:0]};
                if (n_pend == 2'd0 && point_bad(n_cp, r_seq)) n_err = ERR_POINT;
            end
        end
    end

    // Verdict on the final byte: length beats truncation beats the first decode error.
    always_comb begin
        code = n_err;
        if (n_pend != 2'd0) code = ERR_TRUNC;
        if (n_cnt > {1'b0, i_max_bytes}) code = ERR_LONG;
        o_result.error_code = code;
        o_result.valid_res  = (code == ERR_NONE);
    end

    // State registers, cleared at the end of every string.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_seq  <= 2'd0;
            r_cp   <= 21'd0;
            r_cnt  <= 13'd0;
            r_err  <= ERR_NONE;
        end else if (i_take) begin
            if (i_item.last_byte) begin
                r_pend <= 2'd0;
                r_seq  <= 2'd0;
                r_cp   <= 21'd0;
                r_cnt  <= 13'd0;
                r_err  <= ERR_NONE;
            end else begin
                r_pend <= n_pend;
                r_seq  <= n_seq;
                r_cp   <= n_cp;
                r_cnt  <= n_cnt;
                r_err  <= n_err;
            end
        end
    end

    // The end of a string leaves the decoder empty.
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_item.last_byte |=> r_cnt == 13'd0 && r_pend == 2'd0 && r_err == ERR_NONE)
        else $error("decoder state not cleared after final byte");

    // Owed bytes never exceed the length of the sequence that opened them.
    a_pend_within_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= r_seq)
        else $error("pending continuations exceed sequence length");

    // Length and truncation errors exist only in the verdict, never in the held state.
    a_err_held_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err != ERR_LONG && r_err != ERR_TRUNC)
        else $error("held error is a verdict-only code");

    // A mid-string byte advances the counter by one until it saturates.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && !i_item.last_byte && r_cnt != COUNT_MAX |=> r_cnt == $past(r_cnt) + 13'd1)
        else $error("byte counter did not advance");

endmodule

// ----- rtl/core/utf8_text_validator_top.sv -----
// Top level of the strict UTF-8 text validator: channel registers and the limit register.
//
// Usage: a string is sent one byte per request on the input channel (i_in_valid,
// o_in_stall, i_text_byte, i_last_byte), with i_last_byte set on its final byte.
// Exactly one request per string leaves on the output channel (o_out_valid,
// i_out_stall, o_valid_res, o_error_code), taken from the final byte; other bytes
// produce nothing. o_error_code is 0 for a good string, else the code of the
// verdict (too long, bad lead, truncated, bad continuation, bad code point).
// o_out_valid rises once the final byte has passed the input register and the decode
// step has written its verdict into the output register; a stalled output can hold the
// byte in the input register before that. Throughput is one byte per cycle while
// o_in_stall is low, since the decode step is combinational.
// When the receiver stalls, the result holds; a further final byte waits in the
// input register and o_in_stall rises only then, while mid-string bytes keep flowing.
// The string length limit is written through i_cfg_we / i_cfg_wdata by the user only
// while idle; the block itself does not enforce this. Synchronous reset clears the valid
// flags of both channel registers and the decode state and sets the limit to 64 bytes.
module utf8_text_validator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_valid_res,
    output logic [2:0]  o_error_code
);
    import utf8v_pkg::*;

    logic [11:0] r_max_bytes;
    logic        r_in_valid;
    t_item       r_item;
    logic        r_out_valid;
    t_result     r_result;
    t_result     dec_result;
    logic        take;

    // A byte in the input register moves on unless it is final and the output is blocked.
    assign take       = r_in_valid && (!r_item.last_byte || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !take;

    // String length limit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= MAX_BYTES_RESET;
        end else if (i_cfg_we) begin
            r_max_bytes <= i_cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item.text_byte <= i_text_byte;
            r_item.last_byte <= i_last_byte;
        end
    end

    utf8v_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_item      (r_item),
        .i_max_bytes (r_max_bytes),
        .o_result    (dec_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && r_item.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && r_item.last_byte) begin
            r_result <= dec_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_valid_res  = r_result.valid_res;
    assign o_error_code = r_result.error_code;

endmodule
